// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the LZW byte encoder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/lzwe_pkg.sv
// Package of the LZW byte encoder: sizes, hash-table slot layout, hash function,
// controller states and the command/status structs. No dependencies.
package lzwe_pkg;

    localparam int DICT_BITS  = 12;
    localparam int DICT_SIZE  = 1 << DICT_BITS;
    localparam int FIRST_FREE = 256;
    localparam int BYTE_W     = 8;
    localparam int OUT_W      = 12;
    localparam int EPOCH_W    = 4;
    localparam int TBL_BITS   = DICT_BITS + 1;
    localparam int TBL_DEPTH  = 1 << TBL_BITS;
    localparam int SLOT_W     = EPOCH_W + DICT_BITS + BYTE_W + DICT_BITS;

    // One hash-table slot. A slot whose epoch differs from the current one is empty.
    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [DICT_BITS-1:0] prefix;
        logic [BYTE_W-1:0]    byte_val;
        logic [DICT_BITS-1:0] code;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE,
        S_EMIT_MISS,
        S_EMIT_LAST
    } t_state;

    typedef struct packed {
        logic accept;
        logic first;
        logic hit;
        logic next_probe;
        logic emit_miss;
        logic emit_last;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic have_match;
        logic eod;
        logic hit;
        logic empty;
        logic out_ready;
        logic epoch_last;
        logic clr_last;
    } t_status;

    function automatic logic [TBL_BITS-1:0] slot_hash(
        input logic [DICT_BITS-1:0] prefix,
        input logic [BYTE_W-1:0]    byte_val
    );
        return TBL_BITS'(prefix) ^ (TBL_BITS'(byte_val) << (TBL_BITS - BYTE_W));
    endfunction

endpackage

// File: hw/rtl/lzwe_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lzwe_ctrl.sv
// Controller of the LZW byte encoder: sequences accept, probe, emit and clear steps.
// Depends on lzwe_pkg.
module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.have_match ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.empty) begin
                    n_state = S_EMIT_MISS;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_state = i_sts.eod ? S_EMIT_LAST : S_IDLE;
            end
            S_EMIT_MISS: begin
                if (i_sts.out_ready) begin
                    n_state = S_DONE;
                end
            end
            S_EMIT_LAST: begin
                if (i_sts.out_ready) begin
                    n_state = i_sts.epoch_last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                o_cmd.first  = i_in_valid & ~i_sts.have_match;
            end
            S_READ: begin
            end
            S_CHECK: begin
                o_cmd.hit        = i_sts.hit;
                o_cmd.next_probe = ~i_sts.hit & ~i_sts.empty;
            end
            S_DONE: begin
            end
            S_EMIT_MISS: begin
                o_cmd.emit_miss = i_sts.out_ready;
            end
            S_EMIT_LAST: begin
                o_cmd.emit_last = i_sts.out_ready;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/lzwe_dp.sv
// Datapath of the LZW byte encoder: match state, hash-table probing and the
// output register. Depends on lzwe_pkg and lzwe_ram.
module lzwe_dp
    import lzwe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_data,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_status           o_sts,
    output logic [OUT_W-1:0]  o_lzw_code,
    output logic              o_last,
    output logic              o_out_valid
);

    logic [BYTE_W-1:0]    r_byte,       n_byte;
    logic                 r_eod,        n_eod;
    logic [DICT_BITS-1:0] r_current,    n_current;
    logic                 r_have_match, n_have_match;
    logic [DICT_BITS:0]   r_next_free,  n_next_free;
    logic [TBL_BITS-1:0]  r_probe,      n_probe;
    logic [EPOCH_W-1:0]   r_epoch,      n_epoch;
    logic [TBL_BITS-1:0]  r_clr_addr,   n_clr_addr;
    logic                 r_out_valid,  n_out_valid;
    logic [OUT_W-1:0]     r_lzw_code,   n_lzw_code;
    logic                 r_out_last,   n_out_last;

    t_slot               rd_slot;
    t_slot               wr_slot;
    logic [SLOT_W-1:0]   rd_data;
    logic                ram_we;
    logic [TBL_BITS-1:0] wr_addr;
    logic                dict_full;
    logic                out_ready;

    assign dict_full = r_next_free[DICT_BITS];
    assign out_ready = ~r_out_valid | ~i_out_stall;
    assign rd_slot   = t_slot'(rd_data);

    // Hash-table writes: zeroing during the clearing pass, or, while the dictionary is not
    // full, the new entry placed in the empty slot where the probe ended.
    always_comb begin
        wr_slot = '0;
        if (!i_cmd.clear_step) begin
            wr_slot.epoch    = r_epoch;
            wr_slot.prefix   = r_current;
            wr_slot.byte_val = r_byte;
            wr_slot.code     = r_next_free[DICT_BITS-1:0];
        end
    end

    assign ram_we  = i_cmd.clear_step | (i_cmd.emit_miss & ~dict_full);
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : r_probe;

    lzwe_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_rd_addr (r_probe),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_byte       = r_byte;
        n_eod        = r_eod;
        n_current    = r_current;
        n_have_match = r_have_match;
        n_next_free  = r_next_free;
        n_probe      = r_probe;
        n_epoch      = r_epoch;
        n_clr_addr   = r_clr_addr;
        n_lzw_code   = r_lzw_code;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid & i_out_stall;

        if (i_cmd.accept) begin
            n_byte  = i_data_byte;
            n_eod   = i_end_of_data;
            n_probe = slot_hash(r_current, i_data_byte);
        end
        if (i_cmd.first) begin
            n_current    = DICT_BITS'(i_data_byte);
            n_have_match = 1'b1;
        end
        if (i_cmd.hit) begin
            n_current = rd_slot.code;
        end
        if (i_cmd.next_probe) begin
            n_probe = r_probe + 1'b1;
        end
        if (i_cmd.emit_miss) begin
            n_out_valid = 1'b1;
            n_lzw_code  = OUT_W'(r_current);
            n_out_last  = 1'b0;
            n_current   = DICT_BITS'(r_byte);
            if (!dict_full) begin
                n_next_free = r_next_free + 1'b1;
            end
        end
        if (i_cmd.emit_last) begin
            n_out_valid  = 1'b1;
            n_lzw_code   = OUT_W'(r_current);
            n_out_last   = 1'b1;
            n_current    = '0;
            n_have_match = 1'b0;
            n_next_free  = (DICT_BITS + 1)'(FIRST_FREE);
            // A new stream gets a fresh epoch; the last epoch is followed by a clear.
            if (!(&r_epoch)) begin
                n_epoch = r_epoch + 1'b1;
            end
        end
        if (i_cmd.clear_step) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                n_epoch = EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current    <= '0;
            r_have_match <= 1'b0;
            r_next_free  <= (DICT_BITS + 1)'(FIRST_FREE);
            r_epoch      <= EPOCH_W'(1);
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_current    <= n_current;
            r_have_match <= n_have_match;
            r_next_free  <= n_next_free;
            r_epoch      <= n_epoch;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_eod      <= n_eod;
        r_probe    <= n_probe;
        r_lzw_code <= n_lzw_code;
        r_out_last <= n_out_last;
    end

    always_comb begin
        o_sts.have_match = r_have_match;
        o_sts.eod        = r_eod;
        o_sts.hit        = (rd_slot.epoch == r_epoch) && (rd_slot.prefix == r_current)
                           && (rd_slot.byte_val == r_byte);
        o_sts.empty      = (rd_slot.epoch != r_epoch);
        o_sts.out_ready  = out_ready;
        o_sts.epoch_last = &r_epoch;
        o_sts.clr_last   = &r_clr_addr;
    end

    assign o_lzw_code  = r_lzw_code;
    assign o_last      = r_out_last;
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/lzw_byte_encoder_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_data_byte, i_end_of_data
// output    out        o_out_valid / i_out_stall  o_lzw_code, o_last
//
// A stream's first byte passes IDLE and DONE. Any other byte passes IDLE, READ,
// CHECK and DONE on a hit in the first probed slot, adds EMIT_MISS before DONE on a
// miss, and READ and CHECK again per further probe; the hash-table probe loop
// through the single registered RAM read port sets this. A stream's last byte adds
// EMIT_LAST for the final code. After reset, and after every 15th end of stream, a
// clearing pass over all 8192 table slots runs with the input stalled. A stalled
// output holds one code and delays the block only when a second code is due.
//
// Top level of the LZW byte encoder. Depends on lzwe_pkg, lzwe_ctrl, lzwe_dp and
// assert_macros.svh.
`include "assert_macros.svh"

module lzw_byte_encoder_top
    import lzwe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [OUT_W-1:0]  o_lzw_code,
    output logic              o_last
);

    t_cmd    cmd;
    t_status sts;
    logic    in_ready;

    lzwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    lzwe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_lzw_code    (o_lzw_code),
        .o_last        (o_last),
        .o_out_valid   (o_out_valid)
    );

    assign o_in_stall = ~in_ready;

    `ASSERT_SAME(a_emit_has_room, i_clk, i_rst_n, cmd.emit_miss || cmd.emit_last, sts.out_ready)
    `ASSERT_SAME(a_miss_needs_match, i_clk, i_rst_n, cmd.emit_miss, sts.have_match)
    `ASSERT_NEXT(a_flush_ends_match, i_clk, i_rst_n, cmd.emit_last, !sts.have_match && o_out_valid)

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of lzw_byte_encoder_top: directed and random byte streams are
// compared code by code with an LZW phrase-table predictor. Depends on lzwe_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top
    import lzwe_pkg::*;
();

    localparam int MAX_CYCLES = 1_000_000;
    localparam int RANDOM_BYTES = 1360;
    localparam int LONG_HOLD = 400;

    typedef logic [BYTE_W-1:0] t_octet;
    typedef logic [OUT_W-1:0] t_code;

    typedef struct packed {
        t_code code;
        logic  last;
    } t_code_entry;

    // One directed transaction; when typed is set, n/c0/l0/c1/l1 give the codes it causes.
    typedef struct packed {
        t_octet     data;
        logic       eod;
        logic       typed;
        logic [1:0] n;
        t_code      c0;
        logic       l0;
        t_code      c1;
        logic       l1;
    } t_stim_row;

    localparam t_code FIRST_CODE = OUT_W'(FIRST_FREE);

    localparam t_stim_row DIR_ROWS [25] = '{
        // Single-byte streams at both byte extremes, straight after reset.
        '{8'h00, 1'b1, 1'b1, 2'd1, 12'h000, 1'b1, 12'h000, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 2'd1, 12'h0FF, 1'b1, 12'h000, 1'b0},
        // A A A A: first byte, miss, hit on the first entry, miss on the final byte.
        '{8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd1, 12'h041, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b1, 1'b1, 2'd2, FIRST_CODE, 1'b0, 12'h041, 1'b1},
        // A B A B A B A B: growing matches.
        '{8'h41, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h42, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h42, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h42, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h41, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h42, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        // Extremes, mostly alternating, then alternating values at the midpoint.
        '{8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'h80, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        // Hit on the final byte: a single code with last set.
        '{8'hAA, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0},
        '{8'hAA, 1'b0, 1'b1, 2'd1, 12'h0AA, 1'b0, 12'h000, 1'b0},
        '{8'hAA, 1'b1, 1'b1, 2'd1, FIRST_CODE, 1'b1, 12'h000, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_octet     i_data_byte = '0;
    logic       i_end_of_data = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_code      o_lzw_code;
    logic       o_last;

    lzw_byte_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lzw_code    (o_lzw_code),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: current match, phrase table keyed by {prefix, byte}, next free code.
    t_code      match_code = '0;
    bit         match_open = 1'b0;
    int         next_code = FIRST_FREE;
    t_code      phrase_table [logic [DICT_BITS+BYTE_W-1:0]];

    t_code_entry pending_codes [$];

    int errors = 0;
    int codes_checked = 0;
    int bytes_sent = 0;
    int streams_sent = 0;
    int cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_request = 1'b0;

    function automatic int encode_byte(input t_octet b, input bit e, output t_code_entry res [2]);
        int n;
        logic [DICT_BITS+BYTE_W-1:0] key;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (!match_open) begin
            match_code = t_code'(b);
            match_open = 1'b1;
        end else begin
            key = {match_code, b};
            if (phrase_table.exists(key)) begin
                match_code = phrase_table[key];
            end else begin
                res[n] = '{match_code, 1'b0};
                n++;
                // Once the table is full it is frozen until the stream ends.
                if (next_code < DICT_SIZE) begin
                    phrase_table[key] = t_code'(next_code);
                    next_code++;
                end
                match_code = t_code'(b);
            end
        end
        if (e) begin
            res[n] = '{match_code, 1'b1};
            n++;
            match_code = '0;
            match_open = 1'b0;
            next_code = FIRST_FREE;
            phrase_table.delete();
        end
        return n;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_byte(input t_stim_row row);
        t_code_entry res [2];
        int n;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= row.data;
        i_end_of_data <= row.eod;
        do @(posedge i_clk); while (o_in_stall);
        n = encode_byte(row.data, row.eod, res);
        if (row.typed) begin
            if (row.n > 0) pending_codes.push_back('{row.c0, row.l0});
            if (row.n > 1) pending_codes.push_back('{row.c1, row.l1});
        end else begin
            for (int k = 0; k < n; k++)
                pending_codes.push_back(res[k]);
        end
        bytes_sent++;
        if (row.eod)
            streams_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_plain(input t_octet b, input bit e);
        t_stim_row row;
        row = '0;
        row.data = b;
        row.eod = e;
        send_byte(row);
    endtask

    // A stream over a small random alphabet, or over all bytes when alpha_n is zero.
    task automatic send_stream(input int len, input int alpha_n, inout int count);
        t_octet alpha [16];
        t_octet b;
        for (int k = 0; k < 16; k++)
            alpha[k] = t_octet'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            if (alpha_n == 0)
                b = t_octet'($urandom_range(0, 255));
            else
                b = alpha[$urandom_range(0, alpha_n - 1)];
            send_plain(b, i == len - 1);
            count++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int rnd_count;
        int kind;
        bit held;
        bit drained;
        rnd_count = 0;
        held = 1'b0;
        drained = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r])
            send_byte(DIR_ROWS[r]);

        while (rnd_count < RANDOM_BYTES) begin
            if (!held && rnd_count >= 500) begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            if (!drained && rnd_count >= 800) begin
                wait_drained();
                drained = 1'b1;
            end
            if (rnd_count >= RANDOM_BYTES - 200) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0: send_stream(1, 0, rnd_count);
                1, 2, 3: send_stream($urandom_range(2, 60), $urandom_range(1, 4), rnd_count);
                4, 5: send_stream($urandom_range(2, 80), 16, rnd_count);
                default: send_stream($urandom_range(1, 30), 0, rnd_count);
            endcase
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        $display("Sent %0d bytes in %0d streams and checked %0d codes,",
                 bytes_sent, streams_sent, codes_checked);
        $display("with idle bursts on both sides, one long output hold and one full drain.");
        if (errors == 0)
            $display("[lzw_byte_encoder_top] OK");
        else
            $display("[lzw_byte_encoder_top] ERROR");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off while the sender keeps going.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    bit    out_hold_valid = 1'b0;
    t_code out_hold_code = '0;
    logic  out_hold_last = 1'b0;

    always @(posedge i_clk) begin : out_check
        t_code_entry want;
        if (i_rst_n) begin
            // A stalled transaction must stay offered and unchanged.
            if (out_hold_valid && !(o_out_valid && o_lzw_code == out_hold_code
                                    && o_last == out_hold_last)) begin
                $error("out: stalled code changed or dropped (was %0d last %0d)",
                       out_hold_code, out_hold_last);
                errors++;
            end
            out_hold_valid <= o_out_valid && i_out_stall;
            out_hold_code  <= o_lzw_code;
            out_hold_last  <= o_last;
            if (o_out_valid && !i_out_stall) begin
                if (pending_codes.size() == 0) begin
                    $error("lzw_code: no code expected, got %0d (last %0d)", o_lzw_code, o_last);
                    errors++;
                end else begin
                    want = pending_codes.pop_front();
                    if (o_lzw_code !== want.code) begin
                        $error("lzw_code: expected %0d, got %0d", want.code, o_lzw_code);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        errors++;
                    end
                    codes_checked++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("Timeout after %0d cycles with %0d codes outstanding.",
                     cycles, pending_codes.size());
            $display("[lzw_byte_encoder_top] ERROR");
            $finish;
        end
    end

endmodule
